FILE: rtl/mklv_pkg.sv
// shared types and constants of the ts metadata klv frame filter
// no dependencies; imported by every module of the block
package mklv_pkg;

   // frame layout: ethernet 14 + ip 20 + udp 8 bytes ahead of the ts packets
   localparam int unsigned DEF_MAX_FRAME_BYTES = 2048;
   localparam int unsigned TS_PACKET_BYTES     = 188;
   localparam int unsigned PROTO_POS           = 23;
   localparam int unsigned TS_START_POS        = 42;

   localparam logic [7:0] PROTO_UDP      = 8'h11;
   localparam logic [7:0] TS_SYNC        = 8'h47;
   localparam logic [7:0] KLV_INDEF_LEN  = 8'h80;
   localparam logic [7:0] KLV_MAX_PREFIX = 8'h83;
   localparam logic [1:0] AFC_PAYLOAD    = 2'b01;
   localparam logic [2:0] TS_PKT_IDX_MAX = 3'd7;

   // register reset values
   localparam logic [12:0] RST_KLV_PID           = 13'h101;
   localparam logic [7:0]  RST_KLV_PREFIX_OFFSET = 8'd34;
   localparam logic [2:0]  RST_MAX_TS_PACKETS    = 3'd7;

   // register indexes
   localparam logic [1:0] CSR_KLV_PID           = 2'd0;
   localparam logic [1:0] CSR_KLV_PREFIX_OFFSET = 2'd1;
   localparam logic [1:0] CSR_MAX_TS_PACKETS    = 2'd2;

   typedef struct packed {
      logic [12:0] klv_pid;
      logic [7:0]  klv_prefix_offset;
      logic [2:0]  max_ts_packets;
   } cfg_type;

   typedef struct packed {
      logic vld;
      logic verdict;
   } result_type;

endpackage

FILE: rtl/mklv_parse.sv
// per-byte frame parser: position counter, udp check, ts packet walk and verdict
// depends on mklv_pkg
module mklv_parse #(
   parameter int unsigned MAX_FRAME_BYTES = mklv_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic [7:0]           data_byte,
   input  logic                 frame_end,
   input  mklv_pkg::cfg_type    cfg,
   output mklv_pkg::result_type result
);
   import mklv_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(MAX_FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_PROTO  = POS_W'(PROTO_POS);
   localparam logic [POS_W-1:0] POS_TS     = POS_W'(TS_START_POS);
   localparam logic [7:0]       BYTE_LAST  = 8'(TS_PACKET_BYTES - 1);
   localparam logic [7:0]       PKT_BYTES  = 8'(TS_PACKET_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             is_udp_ff, is_udp_in;
   logic [7:0]       byte_idx_ff, byte_idx_in;
   logic [2:0]       pkt_idx_ff, pkt_idx_in;
   logic [4:0]       pid_hi_ff, pid_hi_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic             tent_drop_ff, tent_drop_in;
   logic             decided_ff, decided_in;
   logic             drop_ff, drop_in;
   logic             active;
   logic             ts_go;

   assign active = (pos_ff != POS_LAST);
   assign ts_go  = active && (pos_ff >= POS_TS) && is_udp_ff;

   always_comb begin
      pos_in       = active ? pos_ff + 1'b1 : pos_ff;
      is_udp_in    = is_udp_ff;
      byte_idx_in  = byte_idx_ff;
      pkt_idx_in   = pkt_idx_ff;
      pid_hi_in    = pid_hi_ff;
      hdr_ok_in    = hdr_ok_ff;
      tent_drop_in = tent_drop_ff;
      decided_in   = decided_ff;
      drop_in      = drop_ff;

      if (active && pos_ff == POS_PROTO) begin
         is_udp_in = (data_byte == PROTO_UDP);
      end

      if (ts_go) begin
         case (byte_idx_ff)
            8'd0: begin
               hdr_ok_in    = (data_byte == TS_SYNC);
               tent_drop_in = (cfg.klv_prefix_offset >= PKT_BYTES);
            end
            8'd1: pid_hi_in = data_byte[4:0];
            8'd2: hdr_ok_in = hdr_ok_ff && ({pid_hi_ff, data_byte} == cfg.klv_pid);
            8'd3: hdr_ok_in = hdr_ok_ff && (data_byte[5:4] == AFC_PAYLOAD);
            default: ;
         endcase

         if (byte_idx_ff == cfg.klv_prefix_offset) begin
            tent_drop_in = (data_byte == KLV_INDEF_LEN) || (data_byte > KLV_MAX_PREFIX);
         end

         // last byte of a ts packet: the first qualifying packet decides
         if (byte_idx_ff == BYTE_LAST) begin
            if (!decided_ff && hdr_ok_in && pkt_idx_ff < cfg.max_ts_packets) begin
               decided_in = 1'b1;
               drop_in    = tent_drop_in;
            end
            byte_idx_in = '0;
            if (pkt_idx_ff != TS_PKT_IDX_MAX) begin
               pkt_idx_in = pkt_idx_ff + 1'b1;
            end
         end else begin
            byte_idx_in = byte_idx_ff + 1'b1;
         end
      end
   end

   assign result.vld     = in_accept && frame_end;
   assign result.verdict = decided_in && drop_in;

   always_ff @(posedge clock) begin
      if (reset || (in_accept && frame_end)) begin
         pos_ff       <= '0;
         is_udp_ff    <= 1'b0;
         byte_idx_ff  <= '0;
         pkt_idx_ff   <= '0;
         pid_hi_ff    <= '0;
         hdr_ok_ff    <= 1'b0;
         tent_drop_ff <= 1'b0;
         decided_ff   <= 1'b0;
         drop_ff      <= 1'b0;
      end else if (in_accept) begin
         pos_ff       <= pos_in;
         is_udp_ff    <= is_udp_in;
         byte_idx_ff  <= byte_idx_in;
         pkt_idx_ff   <= pkt_idx_in;
         pid_hi_ff    <= pid_hi_in;
         hdr_ok_ff    <= hdr_ok_in;
         tent_drop_ff <= tent_drop_in;
         decided_ff   <= decided_in;
         drop_ff      <= drop_in;
      end
   end

   // packet walk never runs past the packet length
   a_byte_idx_range: assert property (@(posedge clock) disable iff (reset)
      byte_idx_ff < PKT_BYTES)
      else $error("ts byte index out of range");

   // end beat clears the frame state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      in_accept && frame_end |=> pos_ff == '0 && !decided_ff && !is_udp_ff)
      else $error("frame state not cleared after end beat");

   // a decision is only taken after at least one full packet past the udp header
   a_decided_late: assert property (@(posedge clock) disable iff (reset)
      decided_ff |-> is_udp_ff && pos_ff >= POS_W'(TS_START_POS + TS_PACKET_BYTES))
      else $error("verdict decided too early in the frame");

endmodule

FILE: rtl/mklv_skid.sv
// two-entry result buffer: output register plus skid stage for the verdict beats
// depends on mklv_pkg
module mklv_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  mklv_pkg::result_type push,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_verdict
);
   import mklv_pkg::*;

   logic out_vld_ff, out_vld_in;
   logic out_dat_ff, out_dat_in;
   logic skid_vld_ff, skid_vld_in;
   logic skid_dat_ff, skid_dat_in;
   logic pop;

   assign pop        = out_vld_ff && out_ready;
   assign push_ready = !skid_vld_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_dat_in  = out_dat_ff;
      skid_vld_in = skid_vld_ff;
      skid_dat_in = skid_dat_ff;
      if (!out_vld_ff || pop) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_dat_in  = skid_dat_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = push.vld;
            out_dat_in = push.verdict;
         end
      end else if (push.vld) begin
         skid_vld_in = 1'b1;
         skid_dat_in = push.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_dat_ff  <= out_dat_in;
      skid_dat_ff <= skid_dat_in;
   end

   assign out_valid   = out_vld_ff;
   assign out_verdict = out_dat_ff;

   // skid only fills behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a beat while output register is empty");

   // no push is offered while the skid is occupied
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> !push.vld)
      else $error("result pushed into a full buffer");

   // a skid beat moves forward as soon as the output register drains
   a_skid_forward: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && pop |=> out_vld_ff && !skid_vld_ff && out_dat_ff == $past(skid_dat_ff))
      else $error("skid beat lost on drain");

endmodule

FILE: rtl/mpeg_ts_metadata_klv_filter.sv
// top level of the ts metadata klv frame filter: csr bank, parser and result buffer
// depends on mklv_pkg, mklv_parse, mklv_skid
//
//   channel   dir   beat                          fields
//   req_*     in    one frame byte                tdata: data_byte[7:0]; tlast: frame_end
//   rsp_*     out   one verdict per frame         tdata: verdict[0], zeros above
//   csr_*     in    one register write            addr: index; wdata: value, low bits used
//
// one frame byte is taken every cycle; the parser updates its counters in the
// accepting cycle and the verdict of a frame is registered into the result
// buffer with its last byte. a two-entry result buffer keeps the byte side
// running while a verdict waits; req_tready drops only when both entries are
// full. reset is synchronous and restores the register defaults.
module mpeg_ts_metadata_klv_filter #(
   parameter int unsigned MAX_FRAME_BYTES = mklv_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] verdict, [7:1] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata
);
   import mklv_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   logic       in_accept;
   logic       verdict;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_addr)
            CSR_KLV_PID:           cfg_in.klv_pid           = csr_wdata;
            CSR_KLV_PREFIX_OFFSET: cfg_in.klv_prefix_offset = csr_wdata[7:0];
            CSR_MAX_TS_PACKETS:    cfg_in.max_ts_packets    = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.klv_pid           <= RST_KLV_PID;
         cfg_ff.klv_prefix_offset <= RST_KLV_PREFIX_OFFSET;
         cfg_ff.max_ts_packets    <= RST_MAX_TS_PACKETS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign in_accept = req_tvalid && req_tready;

   mklv_parse #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .data_byte (req_tdata),
      .frame_end (req_tlast),
      .cfg       (cfg_ff),
      .result    (result)
   );

   mklv_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .push        (result),
      .push_ready  (req_tready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_verdict (verdict)
   );

   assign rsp_tdata = {7'b0, verdict};

endmodule
